### rtl/core/skf_pkg.sv
// ============================================================================
// skf_pkg: shared types and microcode for the scalar Kalman filter
// Holds the control word layout, the sequencer flags and the step program.
// ============================================================================
`default_nettype none

package skf_pkg;

    // Fixed-point widths taken from the word fields.
    localparam int unsigned DATA_W    = 16;  // Q4.12 values
    localparam int unsigned GAIN_W    = 17;  // Q1.16 gain, 65536 is 1.0
    localparam int unsigned DIV_STEPS = 17;  // one quotient bit per step
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned PC_W      = 3;

    localparam logic [DATA_W-1:0] NOISE_RESET = 16'd410;   // about 0.1
    localparam logic [DATA_W-1:0] COV_RESET   = 16'd4096;  // 1.0

    // Program addresses.
    localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] STEP_LOAD  = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd2;
    localparam logic [PC_W-1:0] STEP_MUL   = 3'd3;
    localparam logic [PC_W-1:0] STEP_UPD   = 3'd4;
    localparam logic [PC_W-1:0] STEP_WRITE = 3'd5;
    localparam logic [PC_W-1:0] STEP_RET   = 3'd6;
    localparam logic [PC_W-1:0] STEP_GZERO = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LOAD,
        OP_DIV,
        OP_GZERO,
        OP_MUL,
        OP_UPD,
        OP_WRITE
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DEN_ZERO,
        COND_COUNT_NZ,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            ready;
    } t_ctrl_word;

    typedef struct packed {
        logic in_valid;
        logic den_zero;
        logic out_busy;
    } t_flags;

    // The step program. A taken jump goes to target, otherwise to the next step.
    function automatic t_ctrl_word skf_rom(input logic [PC_W-1:0] pc);
        t_ctrl_word w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT, ready: 1'b0};
        case (pc)
            STEP_WAIT: begin
                w = '{op: OP_ACCEPT, cond: COND_NO_INPUT, target: STEP_WAIT, ready: 1'b1};
            end
            STEP_LOAD: begin
                w = '{op: OP_LOAD, cond: COND_DEN_ZERO, target: STEP_GZERO, ready: 1'b0};
            end
            STEP_DIV: begin
                w = '{op: OP_DIV, cond: COND_COUNT_NZ, target: STEP_DIV, ready: 1'b0};
            end
            STEP_MUL: begin
                w = '{op: OP_MUL, cond: COND_NONE, target: STEP_WAIT, ready: 1'b0};
            end
            STEP_UPD: begin
                w = '{op: OP_UPD, cond: COND_NONE, target: STEP_WAIT, ready: 1'b0};
            end
            STEP_WRITE: begin
                w = '{op: OP_WRITE, cond: COND_OUT_BUSY, target: STEP_WRITE, ready: 1'b0};
            end
            STEP_RET: begin
                w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT, ready: 1'b0};
            end
            STEP_GZERO: begin
                w = '{op: OP_GZERO, cond: COND_ALWAYS, target: STEP_MUL, ready: 1'b0};
            end
            default: begin
                w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT, ready: 1'b0};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/skf_seq.sv
// ============================================================================
// skf_seq: microcode sequencer for the scalar Kalman filter
// Step counter, iteration counter and jump logic over the program table.
// ============================================================================
`default_nettype none

module skf_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire skf_pkg::t_flags     i_flags,
    output skf_pkg::t_ctrl_word      o_word
);

    logic [skf_pkg::PC_W-1:0]  r_pc;
    logic [skf_pkg::PC_W-1:0]  n_pc;
    logic [skf_pkg::CNT_W-1:0] r_cnt;
    logic [skf_pkg::CNT_W-1:0] n_cnt;
    logic                      jump;

    assign o_word = skf_pkg::skf_rom(r_pc);

    always_comb begin
        case (o_word.cond)
            skf_pkg::COND_NONE:     jump = 1'b0;
            skf_pkg::COND_ALWAYS:   jump = 1'b1;
            skf_pkg::COND_NO_INPUT: jump = !i_flags.in_valid;
            skf_pkg::COND_DEN_ZERO: jump = i_flags.den_zero;
            skf_pkg::COND_COUNT_NZ: jump = (r_cnt != '0);
            skf_pkg::COND_OUT_BUSY: jump = i_flags.out_busy;
            default:                jump = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = jump ? o_word.target : r_pc + skf_pkg::PC_W'(1);
    end

    // The iteration counter is loaded ahead of the divide loop.
    always_comb begin
        n_cnt = r_cnt;
        case (o_word.op)
            skf_pkg::OP_LOAD: n_cnt = skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);
            skf_pkg::OP_DIV:  n_cnt = r_cnt - skf_pkg::CNT_W'(1);
            default:          n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= skf_pkg::STEP_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    a_reset_to_wait: assert property (@(posedge i_clk)
        !i_rst_n |=> r_pc == skf_pkg::STEP_WAIT)
        else $error("sequencer did not return to the wait step after reset");

    a_div_loop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == skf_pkg::STEP_DIV && r_cnt != '0) |=> r_pc == skf_pkg::STEP_DIV)
        else $error("divide loop left early");

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == skf_pkg::STEP_LOAD && !i_flags.den_zero) |=>
        (r_pc == skf_pkg::STEP_DIV &&
         r_cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)))
        else $error("divide loop not started with a full count");

    a_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == skf_pkg::STEP_WRITE && i_flags.out_busy) |=>
        r_pc == skf_pkg::STEP_WRITE)
        else $error("result step left while the output register was busy");

endmodule

`default_nettype wire

### rtl/core/scalar_kalman_filter.sv
// ============================================================================
// scalar_kalman_filter: one-dimensional Kalman filter for a constant value
// Microcoded datapath with a serial divider and one shared multiplier.
// ============================================================================
// Each accepted measurement word runs the 17-step restoring divide loop for
//   the gain (skipped when noise plus covariance is zero), the two multiplies
//   and the result write, which holds while the output register is busy; a
//   new word is taken only after that result word has been written.
// Reset: synchronous, active low; estimate 0, covariance 1.0, noise about 0.1.
`default_nettype none

module scalar_kalman_filter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration: measurement noise variance, unsigned Q4.12.
    input  wire logic                               i_cfg_we,
    input  wire logic [skf_pkg::DATA_W-1:0]         i_cfg_wdata,
    // Measurement words in.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [skf_pkg::DATA_W-1:0]  i_measurement,
    // Result words out.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [skf_pkg::DATA_W-1:0]       o_estimate,
    output logic [skf_pkg::GAIN_W-1:0]              o_gain,
    output logic [skf_pkg::DATA_W-1:0]              o_covariance
);

    // ------------------------------------------------------------------------
    // Sequencer. The program waits for a word, forms P + R, runs the divide
    // loop for the gain unless P + R is zero, multiplies and writes the result.
    // ------------------------------------------------------------------------
    skf_pkg::t_ctrl_word word;
    skf_pkg::t_flags     flags;

    skf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_word  (word)
    );

    // Architectural state and working registers.
    logic [skf_pkg::DATA_W-1:0]        r_noise;
    logic signed [skf_pkg::DATA_W-1:0] r_est;
    logic [skf_pkg::DATA_W-1:0]        r_cov;
    logic signed [skf_pkg::DATA_W:0]   r_diff;   // measurement minus estimate
    logic [skf_pkg::DATA_W:0]          r_den;    // P + R, 17 bits
    logic [skf_pkg::DATA_W:0]          r_rem;    // partial remainder, below r_den
    logic [skf_pkg::GAIN_W-1:0]        r_quo;    // numerator bits out, gain bits in
    logic signed [35:0]                r_prod;
    logic                              r_out_valid;

    logic accept;
    logic write_en;

    assign o_in_ready     = word.ready;
    assign accept         = word.ready && i_in_valid;
    assign flags.in_valid = i_in_valid;
    assign flags.den_zero = (r_den == '0);
    // The result register may be reloaded on the edge its old word is taken.
    assign flags.out_busy = r_out_valid && !i_out_ready;
    assign write_en       = (word.op == skf_pkg::OP_WRITE) && !flags.out_busy;

    // ------------------------------------------------------------------------
    // Divide step. The rounded numerator is P * 65536 + (P + R) / 2. Its bits
    // above the low seventeen are P / 2, which is always below the divisor, so
    // seventeen restoring steps produce the whole gain. The low seventeen bits
    // are {P[0], 16'b0} plus half the divisor, which never carries out.
    // ------------------------------------------------------------------------
    logic [skf_pkg::DATA_W+1:0] rem_shift;
    logic [skf_pkg::DATA_W+1:0] rem_sub;
    logic                       quo_bit;

    always_comb begin
        rem_shift = {r_rem, r_quo[skf_pkg::GAIN_W-1]};
        rem_sub   = rem_shift - {1'b0, r_den};
        quo_bit   = (rem_shift >= {1'b0, r_den});
    end

    // ------------------------------------------------------------------------
    // Shared 18 x 18 signed multiplier. First it forms gain * (z - x), then
    // P * (1.0 - gain). Its product is registered before any use.
    // ------------------------------------------------------------------------
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;
    logic [skf_pkg::GAIN_W-1:0] one_minus_gain;

    always_comb begin
        one_minus_gain = 17'h10000 - r_quo;
        if (word.op == skf_pkg::OP_MUL) begin
            mul_a = $signed({1'b0, r_quo});
            mul_b = $signed({r_diff[skf_pkg::DATA_W], r_diff});
        end else begin
            mul_a = $signed({2'b00, r_cov});
            mul_b = $signed({1'b0, one_minus_gain});
        end
        mul_p = mul_a * mul_b;
    end

    // ------------------------------------------------------------------------
    // Rounding and saturation. Adding half an LSB and shifting right with the
    // sign kept rounds to nearest with ties toward plus infinity.
    // ------------------------------------------------------------------------
    logic signed [35:0] prod_round;
    logic signed [19:0] delta;
    logic signed [19:0] est_sum;
    logic signed [skf_pkg::DATA_W-1:0] est_sat;
    logic [skf_pkg::DATA_W-1:0] cov_sat;

    always_comb begin
        prod_round = r_prod + 36'sd32768;
        delta      = prod_round[35:16];
        est_sum    = {{4{r_est[skf_pkg::DATA_W-1]}}, r_est} + delta;
        if (est_sum > 20'sd32767) begin
            est_sat = 16'sh7FFF;
        end else if (est_sum < -20'sd32768) begin
            est_sat = 16'sh8000;
        end else begin
            est_sat = est_sum[skf_pkg::DATA_W-1:0];
        end
        // The covariance product is never negative; only the top is clipped.
        if (prod_round[35:32] != 4'd0) begin
            cov_sat = 16'hFFFF;
        end else begin
            cov_sat = prod_round[31:16];
        end
    end

    // ------------------------------------------------------------------------
    // Control state: noise register, filter state and the result flag.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise     <= skf_pkg::NOISE_RESET;
            r_est       <= '0;
            r_cov       <= skf_pkg::COV_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_noise <= i_cfg_wdata;
            end
            if (word.op == skf_pkg::OP_UPD) begin
                r_est <= est_sat;
            end
            if (write_en) begin
                r_cov       <= cov_sat;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        case (word.op)
            skf_pkg::OP_ACCEPT: begin
                if (accept) begin
                    r_diff <= {i_measurement[skf_pkg::DATA_W-1], i_measurement}
                              - {r_est[skf_pkg::DATA_W-1], r_est};
                    r_den  <= {1'b0, r_cov} + {1'b0, r_noise};
                end
            end
            skf_pkg::OP_LOAD: begin
                r_rem <= {2'b00, r_cov[skf_pkg::DATA_W-1:1]};
                r_quo <= {r_cov[0], 16'h0000} + {1'b0, r_den[skf_pkg::DATA_W:1]};
            end
            skf_pkg::OP_DIV: begin
                r_rem <= quo_bit ? rem_sub[skf_pkg::DATA_W:0]
                                 : rem_shift[skf_pkg::DATA_W:0];
                r_quo <= {r_quo[skf_pkg::GAIN_W-2:0], quo_bit};
            end
            skf_pkg::OP_GZERO: begin
                r_quo <= '0;
            end
            skf_pkg::OP_MUL: begin
                r_prod <= mul_p;
            end
            skf_pkg::OP_UPD: begin
                r_prod <= mul_p;
            end
            skf_pkg::OP_WRITE: begin
                if (write_en) begin
                    o_estimate   <= r_est;
                    o_gain       <= r_quo;
                    o_covariance <= cov_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
